/* rtl/aam_pkg.sv */
// ----------------------------------------------------------------------------
// aam_pkg: shared types and constants for the averaged attitude unit
// Command/status structs, state encodings and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package aam_pkg;

    // default depth of the angle history
    localparam int HISTORY_LEN_DEF = 5;

    // cordic datapath widths
    localparam int CW           = 28;
    localparam int ZW           = 25;
    localparam int CORDIC_STEPS = 20;
    localparam int ROOT_STEPS   = 24;
    localparam int SUMW         = 20;

    // angle constants, centidegrees and accumulator units
    localparam logic signed [ZW-1:0] HALF_TURN_ACC = 25'sd4608000;
    localparam logic signed [16:0]   LIM_HALF      = 17'sd18000;
    localparam logic signed [16:0]   LIM_QUARTER   = 17'sd9000;
    localparam logic signed [15:0]   DECL_RESET    = -16'sd1031;

    // which angle the shared cordic is working on
    typedef enum logic [1:0] {
        ANG_ROLL,
        ANG_PITCH,
        ANG_HEAD
    } t_ang;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_ADD,
        S_ROOT,
        S_CINIT,
        S_CSTEP,
        S_CTAKE,
        S_UPDATE,
        S_SUM,
        S_MEAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic       load_in;
        logic       square;
        logic       root_init;
        logic       root_step;
        logic       cordic_init;
        logic       cordic_step;
        logic       cordic_take;
        logic       update;
        logic       sum_step;
        logic       mean;
        logic       out_load;
        t_ang       ang;
        logic [4:0] idx;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    // atan(2^-i) in 1/256 centidegree
    function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:    v = 25'sd1152000;
            5'd1:    v = 25'sd680065;
            5'd2:    v = 25'sd359328;
            5'd3:    v = 25'sd182400;
            5'd4:    v = 25'sd91554;
            5'd5:    v = 25'sd45822;
            5'd6:    v = 25'sd22916;
            5'd7:    v = 25'sd11459;
            5'd8:    v = 25'sd5730;
            5'd9:    v = 25'sd2865;
            5'd10:   v = 25'sd1432;
            5'd11:   v = 25'sd716;
            5'd12:   v = 25'sd358;
            5'd13:   v = 25'sd179;
            5'd14:   v = 25'sd90;
            5'd15:   v = 25'sd45;
            5'd16:   v = 25'sd22;
            5'd17:   v = 25'sd11;
            5'd18:   v = 25'sd6;
            5'd19:   v = 25'sd3;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/aam_ctrl.sv */
// ----------------------------------------------------------------------------
// aam_ctrl: sequencer for the averaged attitude unit
// Steps the datapath through squares, root, three cordic runs and averaging.
// ----------------------------------------------------------------------------
`default_nettype none

module aam_ctrl #(
    parameter int HISTORY_LEN = aam_pkg::HISTORY_LEN_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  aam_pkg::t_status i_status,
    output aam_pkg::t_cmd   o_cmd
);

    aam_pkg::t_state r_state, n_state;
    aam_pkg::t_ang   r_ang, n_ang;
    logic [4:0]      r_cnt, n_cnt;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aam_pkg::S_IDLE;
            r_ang   <= aam_pkg::ANG_ROLL;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ang   <= n_ang;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_ang      = r_ang;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.ang  = r_ang;
        o_cmd.idx  = r_cnt;
        o_in_ready = 1'b0;
        unique case (r_state)
            aam_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = aam_pkg::S_SQUARE;
                end
            end
            aam_pkg::S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = aam_pkg::S_ADD;
            end
            aam_pkg::S_ADD: begin
                o_cmd.root_init = 1'b1;
                n_cnt           = '0;
                n_state         = aam_pkg::S_ROOT;
            end
            aam_pkg::S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 5'd1;
                if (r_cnt == 5'(aam_pkg::ROOT_STEPS - 1)) begin
                    n_ang   = aam_pkg::ANG_ROLL;
                    n_state = aam_pkg::S_CINIT;
                end
            end
            aam_pkg::S_CINIT: begin
                o_cmd.cordic_init = 1'b1;
                n_cnt             = '0;
                n_state           = aam_pkg::S_CSTEP;
            end
            aam_pkg::S_CSTEP: begin
                o_cmd.cordic_step = 1'b1;
                n_cnt             = r_cnt + 5'd1;
                if (r_cnt == 5'(aam_pkg::CORDIC_STEPS - 1)) begin
                    n_state = aam_pkg::S_CTAKE;
                end
            end
            aam_pkg::S_CTAKE: begin
                o_cmd.cordic_take = 1'b1;
                unique case (r_ang)
                    aam_pkg::ANG_ROLL: begin
                        n_ang   = aam_pkg::ANG_PITCH;
                        n_state = aam_pkg::S_CINIT;
                    end
                    aam_pkg::ANG_PITCH: begin
                        n_ang   = aam_pkg::ANG_HEAD;
                        n_state = aam_pkg::S_CINIT;
                    end
                    default: begin
                        n_state = aam_pkg::S_UPDATE;
                    end
                endcase
            end
            aam_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_cnt        = '0;
                n_state      = aam_pkg::S_SUM;
            end
            aam_pkg::S_SUM: begin
                o_cmd.sum_step = 1'b1;
                n_cnt          = r_cnt + 5'd1;
                if (r_cnt == 5'(HISTORY_LEN - 1)) begin
                    n_state = aam_pkg::S_MEAN;
                end
            end
            aam_pkg::S_MEAN: begin
                o_cmd.mean = 1'b1;
                n_state    = aam_pkg::S_FINISH;
            end
            aam_pkg::S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = aam_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = aam_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/aam_dp.sv */
// ----------------------------------------------------------------------------
// aam_dp: datapath of the averaged attitude unit
// Squares, bit-serial root, shared cordic, history stores, stats and output.
// ----------------------------------------------------------------------------
`default_nettype none

module aam_dp #(
    parameter int HISTORY_LEN = aam_pkg::HISTORY_LEN_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  aam_pkg::t_cmd    i_cmd,
    output aam_pkg::t_status o_status,
    input  wire  [79:0]      i_in_data,
    input  wire              i_cfg_we,
    input  wire  [15:0]      i_cfg_data,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output logic [143:0]     o_out_data
);

    localparam int CW   = aam_pkg::CW;
    localparam int ZW   = aam_pkg::ZW;
    localparam int SUMW = aam_pkg::SUMW;
    localparam int SW   = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int TW   = $clog2(HISTORY_LEN + 2);
    localparam int RECIP_SH = 24;
    localparam logic [24:0] RECIP = 25'(((1 << RECIP_SH) + HISTORY_LEN - 1) / HISTORY_LEN);
    localparam logic [SUMW-1:0] HALF_LEN = SUMW'(HISTORY_LEN / 2);

    // sample registers
    logic signed [15:0] r_ax, r_ay, r_az, r_mx, r_my;
    logic signed [15:0] r_decl;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ax <= i_in_data[15:0];
            r_ay <= i_in_data[31:16];
            r_az <= i_in_data[47:32];
            r_mx <= i_in_data[63:48];
            r_my <= i_in_data[79:64];
        end
    end

    // declination register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= aam_pkg::DECL_RESET;
        end else if (i_cfg_we) begin
            r_decl <= i_cfg_data;
        end
    end

    // squares for the pitch denominator
    logic [31:0] r_sqx, r_sqz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sqx <= 32'($signed(r_ax) * $signed(r_ax));
            r_sqz <= 32'($signed(r_az) * $signed(r_az));
        end
    end

    // bit-serial square root, two radicand bits per step
    logic [47:0] r_rad;
    logic [26:0] r_rem;
    logic [23:0] r_root;
    logic [26:0] rem_sh, trial;

    assign rem_sh = {r_rem[24:0], r_rad[47:46]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_init) begin
            r_rad  <= {32'(r_sqx + r_sqz), 16'd0};
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[45:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[22:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[22:0], 1'b0};
            end
        end
    end

    // cordic operand selection and special cases
    logic signed [CW-1:0] op_x, op_y;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_spec;
    logic signed [16:0]   r_spec_val;

    always_comb begin
        case (i_cmd.ang)
            aam_pkg::ANG_ROLL: begin
                op_y = -(CW'(r_ax) <<< 8);
                op_x = CW'(r_az) <<< 8;
            end
            aam_pkg::ANG_PITCH: begin
                op_y = CW'(r_ay) <<< 8;
                op_x = CW'({1'b0, r_root});
            end
            default: begin
                op_y = CW'(r_my) <<< 8;
                op_x = CW'(r_mx) <<< 8;
            end
        endcase
    end

    // cordic micro-rotation
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] ang_step;

    assign dx       = r_x >>> i_cmd.idx;
    assign dy       = r_y >>> i_cmd.idx;
    assign ang_step = aam_pkg::atan_tab(i_cmd.idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_init) begin
            r_spec     <= 1'b0;
            r_spec_val <= '0;
            if (op_y == '0) begin
                r_spec     <= 1'b1;
                r_spec_val <= op_x[CW-1] ? aam_pkg::LIM_HALF : 17'sd0;
            end else if (op_x == '0) begin
                r_spec     <= 1'b1;
                r_spec_val <= op_y[CW-1] ? -aam_pkg::LIM_QUARTER : aam_pkg::LIM_QUARTER;
            end
            if (op_x[CW-1]) begin
                r_x <= -op_x;
                r_y <= -op_y;
                r_z <= op_y[CW-1] ? -aam_pkg::HALF_TURN_ACC : aam_pkg::HALF_TURN_ACC;
            end else begin
                r_x <= op_x;
                r_y <= op_y;
                r_z <= '0;
            end
        end else if (i_cmd.cordic_step) begin
            if (!r_y[CW-1]) begin
                r_x <= r_x + dy;
                r_y <= r_y - dx;
                r_z <= r_z + ang_step;
            end else begin
                r_x <= r_x - dy;
                r_y <= r_y + dx;
                r_z <= r_z - ang_step;
            end
        end
    end

    // round accumulator to centidegrees and saturate
    logic signed [ZW-1:0] z_rnd;
    logic signed [16:0]   ang_c, ang_half, ang_q;

    assign z_rnd = (r_z + 25'sd128) >>> 8;
    always_comb begin
        ang_c = 17'(z_rnd);
        if (r_spec) begin
            ang_half = r_spec_val;
        end else if (z_rnd > ZW'(aam_pkg::LIM_HALF)) begin
            ang_half = aam_pkg::LIM_HALF;
        end else if (z_rnd < -ZW'(aam_pkg::LIM_HALF)) begin
            ang_half = -aam_pkg::LIM_HALF;
        end else begin
            ang_half = ang_c;
        end
        if (ang_half > aam_pkg::LIM_QUARTER) begin
            ang_q = aam_pkg::LIM_QUARTER;
        end else if (ang_half < -aam_pkg::LIM_QUARTER) begin
            ang_q = -aam_pkg::LIM_QUARTER;
        end else begin
            ang_q = ang_half;
        end
    end

    logic signed [15:0] r_roll, r_head_raw;
    logic signed [14:0] r_pitch;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_take) begin
            case (i_cmd.ang)
                aam_pkg::ANG_ROLL:  r_roll     <= 16'(ang_half);
                aam_pkg::ANG_PITCH: r_pitch    <= 15'(ang_q);
                default:            r_head_raw <= 16'(ang_half);
            endcase
        end
    end

    // heading less declination, wrapped once
    logic signed [17:0] h_diff, h_wrap;
    logic signed [15:0] head;

    assign h_diff = 18'(r_head_raw) - 18'(r_decl);
    always_comb begin
        if (h_diff > 18'sd18000) begin
            h_wrap = h_diff - 18'sd36000;
        end else if (h_diff < -18'sd18000) begin
            h_wrap = h_diff + 18'sd36000;
        end else begin
            h_wrap = h_diff;
        end
    end
    assign head = 16'(h_wrap);

    // history stores, extremes, slot and tally
    logic signed [15:0] r_roll_st [HISTORY_LEN];
    logic signed [14:0] r_pitch_st [HISTORY_LEN];
    logic signed [15:0] r_head_st [HISTORY_LEN];
    logic [SW-1:0]      r_slot;
    logic [TW-1:0]      r_tally;
    logic signed [15:0] r_roll_lo, r_roll_hi, r_head_lo, r_head_hi, r_head;
    logic signed [14:0] r_pitch_lo, r_pitch_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HISTORY_LEN; k++) begin
                r_roll_st[k]  <= '0;
                r_pitch_st[k] <= '0;
                r_head_st[k]  <= '0;
            end
            r_slot     <= '0;
            r_tally    <= '0;
            r_roll_lo  <= -16'sd18000;
            r_roll_hi  <= 16'sd18000;
            r_pitch_lo <= -15'sd9000;
            r_pitch_hi <= 15'sd9000;
            r_head_lo  <= -16'sd18000;
            r_head_hi  <= 16'sd18000;
        end else if (i_cmd.update) begin
            r_roll_st[r_slot]  <= r_roll;
            r_pitch_st[r_slot] <= r_pitch;
            r_head_st[r_slot]  <= head;
            r_slot  <= (r_slot == SW'(HISTORY_LEN - 1)) ? '0 : r_slot + 1'b1;
            if (r_tally < TW'(HISTORY_LEN + 1)) begin
                r_tally <= r_tally + 1'b1;
            end
            if (r_roll > r_roll_hi)   r_roll_hi  <= r_roll;
            if (r_roll < r_roll_lo)   r_roll_lo  <= r_roll;
            if (r_pitch > r_pitch_hi) r_pitch_hi <= r_pitch;
            if (r_pitch < r_pitch_lo) r_pitch_lo <= r_pitch;
            if (head > r_head_hi)     r_head_hi  <= head;
            if (head < r_head_lo)     r_head_lo  <= head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_head <= head;
        end
    end

    // store sums, one entry per cycle
    logic signed [SUMW-1:0] r_rs, r_ps, r_hs;
    logic [SW-1:0]          sidx;

    assign sidx = i_cmd.idx[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_rs <= '0;
            r_ps <= '0;
            r_hs <= '0;
        end else if (i_cmd.sum_step) begin
            r_rs <= r_rs + SUMW'(r_roll_st[sidx]);
            r_ps <= r_ps + SUMW'(r_pitch_st[sidx]);
            r_hs <= r_hs + SUMW'(r_head_st[sidx]);
        end
    end

    // rounded means by reciprocal multiply, and the movement flag
    logic [SUMW-1:0]        rs_mag, ps_mag, hs_mag;
    logic [44:0]            r_rp, r_pp, r_hp;
    logic                   r_rneg, r_pneg, r_hneg, r_moving;
    logic signed [SUMW+4:0] roll_x, pitch_x, head_x;

    assign rs_mag = (r_rs[SUMW-1] ? SUMW'(-r_rs) : SUMW'(r_rs)) + HALF_LEN;
    assign ps_mag = (r_ps[SUMW-1] ? SUMW'(-r_ps) : SUMW'(r_ps)) + HALF_LEN;
    assign hs_mag = (r_hs[SUMW-1] ? SUMW'(-r_hs) : SUMW'(r_hs)) + HALF_LEN;
    assign roll_x  = (SUMW+5)'(r_roll)  * (SUMW+5)'(HISTORY_LEN);
    assign pitch_x = (SUMW+5)'(r_pitch) * (SUMW+5)'(HISTORY_LEN);
    assign head_x  = (SUMW+5)'(r_head)  * (SUMW+5)'(HISTORY_LEN);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean) begin
            r_rp     <= 45'(rs_mag) * 45'(RECIP);
            r_pp     <= 45'(ps_mag) * 45'(RECIP);
            r_hp     <= 45'(hs_mag) * 45'(RECIP);
            r_rneg   <= r_rs[SUMW-1];
            r_pneg   <= r_ps[SUMW-1];
            r_hneg   <= r_hs[SUMW-1];
            r_moving <= (roll_x > (SUMW+5)'(r_rs)) || (pitch_x > (SUMW+5)'(r_ps)) ||
                        (head_x > (SUMW+5)'(r_hs));
        end
    end

    logic [16:0] rq, pq, hq;
    logic [15:0] roll_mean, head_mean;
    logic [14:0] pitch_mean;

    assign rq         = r_rp[RECIP_SH+16:RECIP_SH];
    assign pq         = r_pp[RECIP_SH+16:RECIP_SH];
    assign hq         = r_hp[RECIP_SH+16:RECIP_SH];
    assign roll_mean  = r_rneg ? 16'(-rq) : 16'(rq);
    assign pitch_mean = r_pneg ? 15'(-pq) : 15'(pq);
    assign head_mean  = r_hneg ? 16'(-hq) : 16'(hq);

    // output register
    assign o_status.out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_data <= {1'b0, r_head_hi, r_head_lo, r_pitch_hi, r_pitch_lo,
                           r_roll_hi, r_roll_lo, (r_tally > TW'(HISTORY_LEN)),
                           r_moving, head_mean, pitch_mean, roll_mean};
        end
    end

endmodule

`default_nettype wire

/* rtl/attitude_from_accel_mag_averaged_unit.sv */
// An accepted sample passes a 24-step bit-serial root, then one shared 20-step cordic run
// three times, then a sum of the stores at one history entry per cycle, before its result
// beat. One sample is worked on at a time, so no new sample is taken while one is in work;
// the next is taken as soon as the result sits in the output register, which stalls only
// while it holds an untaken beat.
// Reset (synchronous, active low) zeroes the histories, sets the extremes to their
// limits and the declination to -10.31 degrees.
// ----------------------------------------------------------------------------
// attitude_from_accel_mag_averaged_unit: averaged roll, pitch and heading
// Computes tilt and heading angles from one sensor sample and reports averages,
// extremes, a movement flag and a ready flag over a short history.
// ----------------------------------------------------------------------------
`default_nettype none

module attitude_from_accel_mag_averaged_unit #(
    parameter int HISTORY_LEN = aam_pkg::HISTORY_LEN_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // accel_x, accel_y, accel_z, mag_x, mag_y
    input  wire  [79:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // roll_average, pitch_average, heading_average, moving, ready_res,
    // roll_lowest, roll_highest, pitch_lowest, pitch_highest,
    // heading_lowest, heading_highest, one zero pad bit
    output logic [143:0] o_m_axis_tdata,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [15:0]  i_cfg_data
);

    aam_pkg::t_cmd    cmd;
    aam_pkg::t_status status;

    // configuration always taken
    assign o_cfg_ready = 1'b1;

    aam_ctrl #(
        .HISTORY_LEN(HISTORY_LEN)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_s_axis_tvalid),
        .o_in_ready(o_s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    aam_dp #(
        .HISTORY_LEN(HISTORY_LEN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_data  (i_s_axis_tdata),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_out_valid(o_m_axis_tvalid),
        .i_out_ready(i_m_axis_tready),
        .o_out_data (o_m_axis_tdata)
    );

    // busy after a sample beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while a sample is in work");

    // pitch average stays within a quarter turn
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[30:16]) <= 15'sd9000 &&
                             $signed(o_m_axis_tdata[30:16]) >= -15'sd9000))
        else $error("pitch average out of range");

    // roll extremes stay ordered
    a_roll_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[64:49]) <=
                             $signed(o_m_axis_tdata[80:65])))
        else $error("roll lowest above roll highest");

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the averaged attitude unit
// Drives raw sensor samples over the stream input and predicts roll, pitch and
// heading with its own cordic and root model. Every output beat is checked
// field by field. Declination settings and idle gaps are varied along the way.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH      = 5;
    localparam int CYCLE_CAP  = 1000000;
    localparam int DRAIN_WAIT = 150;

    typedef struct {
        int roll_mean, pitch_mean, head_mean, moving, warm;
        int roll_lo, roll_hi, pitch_lo, pitch_hi, head_lo, head_hi;
    } t_attitude;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [79:0]  i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [143:0] o_m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [15:0]  i_cfg_data = '0;

    t_attitude pending_attitude[$];
    int        fail_count = 0;
    int        samples_sent = 0;
    int        beats_seen = 0;
    int        decl_writes = 0;
    int        cycle_count = 0;
    bit        quiet = 1'b0;
    int        sink_hold = 0;

    // model state
    int decl;
    int roll_hist[DEPTH], pitch_hist[DEPTH], head_hist[DEPTH];
    int slot, tally;
    int roll_lo, roll_hi, pitch_lo, pitch_hi, head_lo, head_hi;

    attitude_from_accel_mag_averaged_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // angle of the vector (x, y) in centidegrees, 20-step cordic
    function automatic int vector_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        if (y == 0) return (x < 0) ? 18000 : 0;
        if (x == 0) return (y > 0) ? 9000 : -9000;
        if (x < 0) begin
            z = (y > 0) ? 64'sd4608000 : -64'sd4608000;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < aam_pkg::CORDIC_STEPS; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0) begin
                x += dy; y -= dx; z += longint'(aam_pkg::atan_tab(i[4:0]));
            end else begin
                x -= dy; y += dx; z -= longint'(aam_pkg::atan_tab(i[4:0]));
            end
        end
        z = (z + 128) >>> 8;
        if (z > 18000) z = 18000;
        if (z < -18000) z = -18000;
        return int'(z);
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b; res = (res >> 1) + b;
            end else res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic int rounded_avg(int sum);
        int mag;
        mag = (sum < 0) ? -sum : sum;
        mag = (mag + DEPTH / 2) / DEPTH;
        return (sum < 0) ? -mag : mag;
    endfunction

    task automatic model_reset();
        decl = int'(aam_pkg::DECL_RESET);
        for (int i = 0; i < DEPTH; i++) begin
            roll_hist[i] = 0; pitch_hist[i] = 0; head_hist[i] = 0;
        end
        slot = 0; tally = 0;
        roll_lo = -18000; roll_hi = 18000;
        pitch_lo = -9000; pitch_hi = 9000;
        head_lo = -18000; head_hi = 18000;
    endtask

    // advance the model by one sample and queue the expected beat
    task automatic predict_attitude(logic [79:0] d);
        longint ax, ay, az, mx, my;
        longint unsigned den;
        int roll, pitch, head, rs, ps, hs;
        t_attitude e;
        ax = longint'($signed(d[15:0]));  ay = longint'($signed(d[31:16]));
        az = longint'($signed(d[47:32])); mx = longint'($signed(d[63:48]));
        my = longint'($signed(d[79:64]));
        roll = vector_angle(-ax * 256, az * 256);
        den = int_root(longint'(ax * ax + az * az) << 16);
        pitch = vector_angle(ay * 256, longint'(den));
        if (pitch > 9000) pitch = 9000;
        if (pitch < -9000) pitch = -9000;
        if (my == 0) head = (mx < 0) ? 18000 : 0;
        else head = vector_angle(my * 256, mx * 256);
        head -= decl;
        if (head > 18000) head -= 36000;
        else if (head < -18000) head += 36000;
        roll_hist[slot] = roll; pitch_hist[slot] = pitch; head_hist[slot] = head;
        slot = (slot + 1) % DEPTH;
        if (head > head_hi) head_hi = head;
        if (head < head_lo) head_lo = head;
        if (roll > roll_hi) roll_hi = roll;
        if (roll < roll_lo) roll_lo = roll;
        if (pitch > pitch_hi) pitch_hi = pitch;
        if (pitch < pitch_lo) pitch_lo = pitch;
        rs = 0; ps = 0; hs = 0;
        for (int i = 0; i < DEPTH; i++) begin
            rs += roll_hist[i]; ps += pitch_hist[i]; hs += head_hist[i];
        end
        if (tally < DEPTH + 1) tally++;
        e.roll_mean = rounded_avg(rs);
        e.pitch_mean = rounded_avg(ps);
        e.head_mean = rounded_avg(hs);
        e.moving = (head * DEPTH > hs) || (pitch * DEPTH > ps) || (roll * DEPTH > rs);
        e.warm = (tally > DEPTH);
        e.roll_lo = roll_lo; e.roll_hi = roll_hi;
        e.pitch_lo = pitch_lo; e.pitch_hi = pitch_hi;
        e.head_lo = head_lo; e.head_hi = head_hi;
        pending_attitude.push_back(e);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_attitude e;
        logic [143:0] t;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            t = o_m_axis_tdata;
            beats_seen++;
            if (pending_attitude.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                e = pending_attitude.pop_front();
                check_field("roll_average", e.roll_mean, int'($signed(t[15:0])));
                check_field("pitch_average", e.pitch_mean, int'($signed(t[30:16])));
                check_field("heading_average", e.head_mean, int'($signed(t[46:31])));
                check_field("moving", e.moving, int'(t[47]));
                check_field("ready_res", e.warm, int'(t[48]));
                check_field("roll_lowest", e.roll_lo, int'($signed(t[64:49])));
                check_field("roll_highest", e.roll_hi, int'($signed(t[80:65])));
                check_field("pitch_lowest", e.pitch_lo, int'($signed(t[95:81])));
                check_field("pitch_highest", e.pitch_hi, int'($signed(t[110:96])));
                check_field("heading_lowest", e.head_lo, int'($signed(t[126:111])));
                check_field("heading_highest", e.head_hi, int'($signed(t[142:127])));
            end
        end
    end

    // output back-pressure in short bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) i_m_axis_tready <= 1'b0;
        else if (quiet) i_m_axis_tready <= 1'b1;
        else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            sink_hold <= $urandom_range(0, 2);
            i_m_axis_tready <= 1'b0;
        end else i_m_axis_tready <= 1'b1;
    end

    // the unit stays busy after each accepted beat, so dropping valid between samples
    // costs nothing
    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az, logic signed [15:0] mx,
                               logic signed [15:0] my);
        logic [79:0] d;
        d = {my, mx, az, ay, ax};
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= d;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_attitude(d);
        samples_sent++;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_attitude.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_declination(logic signed [15:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        decl = int'(v);
        decl_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // edges of the input range, zero vectors and the heading axis cases
    task automatic test_directed();
        send_sample(0, 0, 0, 0, 0);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(0, 16'sd1000, 0, -16'sd500, 0);
        send_sample(0, -16'sd1000, 0, 16'sd500, 0);
        send_sample(16'sd1000, 0, 0, 0, 16'sd300);
        send_sample(-16'sd1000, 0, 0, 0, -16'sd300);
        send_sample(0, 0, -16'sd16384, -16'sd32768, 16'sd1);
        send_sample(0, 0, 16'sd16384, -16'sd32768, -16'sd1);
        send_sample(16'sd1, 16'sd32767, 16'sd1, 16'sd1, 16'sd1);
        send_sample(-16'sd1, -16'sd32768, -16'sd1, -16'sd1, -16'sd1);
        send_sample(16'sd12000, -16'sd4000, -16'sd9000, 16'sd2500, -16'sd7000);
    endtask

    // heading wrap at the declination extremes
    task automatic test_declination_sweep();
        logic signed [15:0] setting[6] = '{-16'sd32768, 16'sd32767, -16'sd18000,
                                           16'sd18000, 16'sd0, -16'sd1031};
        foreach (setting[k]) begin
            write_declination(setting[k]);
            send_sample(0, 0, 16'sd100, -16'sd100, 0);
            send_sample(0, 0, 16'sd100, 16'sd100, 0);
            send_sample(0, 0, 16'sd100, 16'sd100, 16'sd100);
            send_sample(0, 0, 16'sd100, -16'sd100, -16'sd100);
        end
    endtask

    // random samples in phases with a fresh declination each time
    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 300 == 299) write_declination(16'($urandom));
            if (n == count - 200) quiet = 1'b1;
            send_sample(rand_axis(), rand_axis(), rand_axis(), rand_axis(), rand_axis());
        end
    endtask

    initial begin
        model_reset();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_declination_sweep();
        test_random(1600);
        wait_drained();
        $display("covered %0d samples, %0d result beats, %0d declination writes",
                 samples_sent, beats_seen, decl_writes);
        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
